### src/bayes_cpt_marginal_probability_macros.svh
// Assertion macros shared by the marginal probability block.
// Depends on nothing; taken in by bcmp_pipe_ctrl, the module that carries assertions.
`ifndef BAYES_CPT_MARGINAL_PROBABILITY_MACROS_SVH
`define BAYES_CPT_MARGINAL_PROBABILITY_MACROS_SVH

// Implication in the same cycle.
`define BCMP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcmp assertion failed");

// Implication checked in the following cycle.
`define BCMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcmp assertion failed");

`endif

### src/bcmp_pkg.sv
// Shared constants, register indexes and the table lookup for the block.
// Depends on nothing.
package bcmp_pkg;

  localparam int PROB_W  = 8;
  localparam int OUT_W   = 7;
  localparam int ENTRY_W = 8;
  localparam int COUNT_W = 3;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 2;

  localparam int FULL_SCALE_DEF = 100;

  localparam logic [CFG_IDX_W-1:0] REG_PARENT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CPT_FIRST    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CPT_SECOND   = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd4;
  localparam logic [COUNT_W-1:0] COUNT_THREE = 3'd3;
  localparam logic [COUNT_W-1:0] COUNT_FOUR  = 3'd4;

  localparam int TP_STAGES  = 6;
  localparam int BL_STAGES  = 4;
  localparam int PIPE_DEPTH = 1 + TP_STAGES + 2 * BL_STAGES;

  function automatic logic [ENTRY_W-1:0] cpt_entry(
    input logic [CFG_W-1:0] first_half,
    input logic [CFG_W-1:0] second_half,
    input logic [3:0]       idx
  );
    logic [CFG_W-1:0] word;
    word = idx[3] ? second_half : first_half;
    return word[idx[2:0] * ENTRY_W +: ENTRY_W];
  endfunction

endpackage

### src/bcmp_if.sv
// Request and result channels of the block, with valid/ready handshake.
// Depends on bcmp_pkg.
interface bcmp_req_if;
  logic                       valid;
  logic                       ready;
  logic [bcmp_pkg::PROB_W-1:0] prob_a;
  logic [bcmp_pkg::PROB_W-1:0] prob_b;
  logic [bcmp_pkg::PROB_W-1:0] prob_c;
  logic [bcmp_pkg::PROB_W-1:0] prob_d;

  modport source(output valid, prob_a, prob_b, prob_c, prob_d, input ready);
  modport sink(input valid, prob_a, prob_b, prob_c, prob_d, output ready);
endinterface

interface bcmp_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bcmp_pkg::OUT_W-1:0] probability;

  modport source(output valid, probability, input ready);
  modport sink(input valid, probability, output ready);
endinterface

### src/bayes_cpt_marginal_probability.sv
// Top level of the Bayesian network marginal probability block.
// Depends on bcmp_pkg, bcmp_if, bcmp_pipe_ctrl, bcmp_two_parent, bcmp_blend.
//
// Usage: requests arrive on the item channel (four parent probabilities);
// each request gives exactly one result on the result channel, in order.
// The table and the parent count are written through the cfg_we, cfg_idx
// and cfg_data port; the user must do so only while no request is in
// flight, as the block itself does not enforce this. There are 15 register
// stages: one clamping stage, six stages for the two-parent form and four
// for each of the two blend levels. One request can be accepted in every
// cycle unless the receiver stalls with every stage full; the rate is set
// by the fully pipelined multipliers.
// Fewer parents are handled by forcing the unused parents to zero, which
// makes the blends pass their lower input through.
// Reset clears the valid bits and sets the parent count to four and the
// table to zero. When the receiver stalls, each stage holds until the one
// after it frees up, so bubbles are squeezed out and the item channel stays
// ready until every stage is full.
module bayes_cpt_marginal_probability #(
  parameter int FULL_SCALE = bcmp_pkg::FULL_SCALE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bcmp_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [bcmp_pkg::CFG_W-1:0]        cfg_data,
  bcmp_req_if.sink                          item,
  bcmp_rsp_if.source                        result
);

  localparam int PW    = $clog2(FULL_SCALE + 1);
  localparam int DEPTH = bcmp_pkg::PIPE_DEPTH;
  localparam int TPS   = bcmp_pkg::TP_STAGES;
  localparam int BLS   = bcmp_pkg::BL_STAGES;

  logic [bcmp_pkg::COUNT_W-1:0] parent_count;
  logic [bcmp_pkg::CFG_W-1:0]   cpt_first_half;
  logic [bcmp_pkg::CFG_W-1:0]   cpt_second_half;

  logic [DEPTH-1:0] ld;
  logic [PW-1:0]    ca;
  logic [PW-1:0]    cb;
  logic [PW-1:0]    cc;
  logic [PW-1:0]    cd;
  logic [PW-1:0]    sa;
  logic [PW-1:0]    sb;
  logic [PW-1:0]    sc;
  logic [PW-1:0]    sd;
  logic [PW-1:0]    cdl [1:TPS];
  logic [PW-1:0]    ddl [1:TPS+BLS];
  logic [PW-1:0]    r   [4];
  logic [PW-1:0]    m0;
  logic [PW-1:0]    m1;
  logic [PW-1:0]    final_prob;

  always_ff @(posedge clk) begin
    if (rst) begin
      parent_count    <= bcmp_pkg::COUNT_RESET;
      cpt_first_half  <= '0;
      cpt_second_half <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        bcmp_pkg::REG_PARENT_COUNT: parent_count <= cfg_data[bcmp_pkg::COUNT_W-1:0];
        bcmp_pkg::REG_CPT_FIRST:    cpt_first_half <= cfg_data;
        bcmp_pkg::REG_CPT_SECOND:   cpt_second_half <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bcmp_pipe_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .ld       (ld)
  );

  assign ca = (item.prob_a > bcmp_pkg::PROB_W'(FULL_SCALE)) ? PW'(FULL_SCALE)
                                                             : PW'(item.prob_a);
  assign cb = (item.prob_b > bcmp_pkg::PROB_W'(FULL_SCALE)) ? PW'(FULL_SCALE)
                                                             : PW'(item.prob_b);
  assign cc = (item.prob_c > bcmp_pkg::PROB_W'(FULL_SCALE)) ? PW'(FULL_SCALE)
                                                             : PW'(item.prob_c);
  assign cd = (item.prob_d > bcmp_pkg::PROB_W'(FULL_SCALE)) ? PW'(FULL_SCALE)
                                                             : PW'(item.prob_d);

  // Counts above four behave as four, below three as two.
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      sa <= ca;
      sb <= cb;
      sc <= (parent_count >= bcmp_pkg::COUNT_THREE) ? cc : '0;
      sd <= (parent_count >= bcmp_pkg::COUNT_FOUR) ? cd : '0;
    end
    if (ld[1]) begin
      cdl[1] <= sc;
      ddl[1] <= sd;
    end
    for (int k = 2; k <= TPS; k++) begin
      if (ld[k]) begin
        cdl[k] <= cdl[k-1];
      end
    end
    for (int k = 2; k <= TPS + BLS; k++) begin
      if (ld[k]) begin
        ddl[k] <= ddl[k-1];
      end
    end
  end

  bcmp_two_parent #(
    .FULL_SCALE(FULL_SCALE)
  ) u_two_parent (
    .clk            (clk),
    .ld             (ld[TPS:1]),
    .a              (sa),
    .b              (sb),
    .cpt_first_half (cpt_first_half),
    .cpt_second_half(cpt_second_half),
    .r              (r)
  );

  bcmp_blend #(
    .FULL_SCALE(FULL_SCALE)
  ) u_blend_c_low (
    .clk(clk),
    .ld (ld[TPS+BLS:TPS+1]),
    .lo (r[0]),
    .hi (r[1]),
    .p  (cdl[TPS]),
    .res(m0)
  );

  bcmp_blend #(
    .FULL_SCALE(FULL_SCALE)
  ) u_blend_c_high (
    .clk(clk),
    .ld (ld[TPS+BLS:TPS+1]),
    .lo (r[2]),
    .hi (r[3]),
    .p  (cdl[TPS]),
    .res(m1)
  );

  bcmp_blend #(
    .FULL_SCALE(FULL_SCALE)
  ) u_blend_d (
    .clk(clk),
    .ld (ld[DEPTH-1:TPS+BLS+1]),
    .lo (m0),
    .hi (m1),
    .p  (ddl[TPS+BLS]),
    .res(final_prob)
  );

  assign result.probability = bcmp_pkg::OUT_W'(final_prob);

endmodule

### src/bcmp_pipe_ctrl.sv
// Valid bits and per-stage load enables of the pipeline.
// Depends on bcmp_pkg and the assertion macro header.
`include "bayes_cpt_marginal_probability_macros.svh"

module bcmp_pipe_ctrl #(
  parameter int DEPTH = bcmp_pkg::PIPE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DEPTH-1:0] ld
);

  logic [DEPTH-1:0] vld;

  // A stage may load unless it and every stage after it are full and the
  // output is held.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      ld[k] = out_ready || !(&(vld | ((DEPTH'(1) << k) - DEPTH'(1))));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < DEPTH; k++) begin
        if (ld[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = vld[DEPTH-1];

  `BCMP_ASSERT_IMP(a_bubble_accepts, clk, rst, vld != '1, in_ready)
  `BCMP_ASSERT_IMP(a_drain_accepts, clk, rst, out_ready, in_ready)
  `BCMP_ASSERT_NEXT(a_count_kept, clk, rst, 1'b1,
    $countones(vld) == $past($countones(vld)) + $past(in_valid && in_ready)
                       - $past(out_valid && out_ready))

endmodule

### src/bcmp_two_parent.sv
// Two-parent form on all four table quarters: weights, weighted terms, sums
// and round-half-up division by the square of full scale. Depends on bcmp_pkg.
module bcmp_two_parent #(
  parameter int FULL_SCALE = bcmp_pkg::FULL_SCALE_DEF
) (
  input  logic                              clk,
  input  logic [bcmp_pkg::TP_STAGES-1:0]    ld,
  input  logic [$clog2(FULL_SCALE+1)-1:0]   a,
  input  logic [$clog2(FULL_SCALE+1)-1:0]   b,
  input  logic [bcmp_pkg::CFG_W-1:0]        cpt_first_half,
  input  logic [bcmp_pkg::CFG_W-1:0]        cpt_second_half,
  output logic [$clog2(FULL_SCALE+1)-1:0]   r [4]
);

  localparam int PW       = $clog2(FULL_SCALE + 1);
  localparam int WW       = $clog2(FULL_SCALE * FULL_SCALE + 1);
  localparam int HALF_SQ  = (FULL_SCALE * FULL_SCALE) / 2;
  localparam int XW       = $clog2(FULL_SCALE * FULL_SCALE * 255 + HALF_SQ + 1);
  localparam int SHIFT    = XW + $clog2(FULL_SCALE);
  localparam int MW       = XW + 2;
  localparam longint unsigned MULT =
    ((64'd1 << SHIFT) + FULL_SCALE - 1) / FULL_SCALE;
  localparam int PDW      = XW + MW;

  logic [PW-1:0]  na;
  logic [PW-1:0]  nb;
  logic [WW-1:0]  w  [4];
  logic [XW-1:0]  t  [4][4];
  logic [XW-1:0]  x  [4];
  logic [PDW-1:0] p1 [4];
  logic [PDW-1:0] p2 [4];
  logic [XW-1:0]  q1 [4];
  logic [XW-1:0]  q2 [4];

  assign na = PW'(FULL_SCALE) - a;
  assign nb = PW'(FULL_SCALE) - b;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      q1[i] = XW'(p1[i] >> SHIFT);
      q2[i] = XW'(p2[i] >> SHIFT);
    end
  end

  // Division by the square is done as two exact divisions by full scale.
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      w[0] <= WW'(na) * WW'(nb);
      w[1] <= WW'(a) * WW'(nb);
      w[2] <= WW'(na) * WW'(b);
      w[3] <= WW'(a) * WW'(b);
    end
    if (ld[1]) begin
      for (int q = 0; q < 4; q++) begin
        for (int j = 0; j < 4; j++) begin
          t[q][j] <= XW'(w[j]) * XW'(bcmp_pkg::cpt_entry(cpt_first_half,
                       cpt_second_half, 4'(q * 4 + j)));
        end
      end
    end
    if (ld[2]) begin
      for (int q = 0; q < 4; q++) begin
        x[q] <= t[q][0] + t[q][1] + t[q][2] + t[q][3] + XW'(HALF_SQ);
      end
    end
    if (ld[3]) begin
      for (int q = 0; q < 4; q++) begin
        p1[q] <= PDW'(x[q]) * PDW'(MULT);
      end
    end
    if (ld[4]) begin
      for (int q = 0; q < 4; q++) begin
        p2[q] <= PDW'(q1[q]) * PDW'(MULT);
      end
    end
    if (ld[5]) begin
      for (int q = 0; q < 4; q++) begin
        r[q] <= (q2[q] > XW'(FULL_SCALE)) ? PW'(FULL_SCALE) : PW'(q2[q]);
      end
    end
  end

endmodule

### src/bcmp_blend.sv
// Blend of two results by an extra parent, with round-half-up division by
// full scale and clamping. Depends on bcmp_pkg.
module bcmp_blend #(
  parameter int FULL_SCALE = bcmp_pkg::FULL_SCALE_DEF
) (
  input  logic                            clk,
  input  logic [bcmp_pkg::BL_STAGES-1:0]  ld,
  input  logic [$clog2(FULL_SCALE+1)-1:0] lo,
  input  logic [$clog2(FULL_SCALE+1)-1:0] hi,
  input  logic [$clog2(FULL_SCALE+1)-1:0] p,
  output logic [$clog2(FULL_SCALE+1)-1:0] res
);

  localparam int PW    = $clog2(FULL_SCALE + 1);
  localparam int BXW   = $clog2(FULL_SCALE * FULL_SCALE + FULL_SCALE / 2 + 1);
  localparam int SHIFT = BXW + $clog2(FULL_SCALE);
  localparam int MW    = BXW + 2;
  localparam longint unsigned MULT =
    ((64'd1 << SHIFT) + FULL_SCALE - 1) / FULL_SCALE;
  localparam int PDW   = BXW + MW;

  logic [PW-1:0]  np;
  logic [BXW-1:0] plo;
  logic [BXW-1:0] phi;
  logic [BXW-1:0] x;
  logic [PDW-1:0] prod;
  logic [BXW-1:0] quot;

  assign np   = PW'(FULL_SCALE) - p;
  assign quot = BXW'(prod >> SHIFT);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      plo <= BXW'(lo) * BXW'(np);
      phi <= BXW'(hi) * BXW'(p);
    end
    if (ld[1]) begin
      x <= plo + phi + BXW'(FULL_SCALE / 2);
    end
    if (ld[2]) begin
      prod <= PDW'(x) * PDW'(MULT);
    end
    if (ld[3]) begin
      res <= (quot > BXW'(FULL_SCALE)) ? PW'(FULL_SCALE) : PW'(quot);
    end
  end

endmodule
